// ----- rtl/longest_palindrome_finder_defines.svh -----
// Assertion macros for the longest palindrome finder.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LONGEST_PALINDROME_FINDER_DEFINES_SVH
`define LONGEST_PALINDROME_FINDER_DEFINES_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define LPF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define LPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lpf_pkg.sv -----
// Shared types, constants and the helper function of the longest palindrome finder.
// No dependencies.
`timescale 1ns / 1ps

package lpf_pkg;

	// Width of one chunk of the final first-hit search, and its index width.
	localparam int SCAN_W  = 8;
	localparam int SCAN_IW = 3;

	// One input item: a string byte and the end-of-string flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} item_t;

	// One result item: slice bounds of the longest palindrome.
	typedef struct packed {
		logic [5:0] start_res;
		logic [6:0] length;
		logic       too_long;
	} result_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic wr;   // a byte is being stored
		logic run;  // one diagonal step
		logic clr;  // return the cells to their idle values
	} cell_ctl_t;

	// Index of the lowest set bit of an 8-bit chunk (zero when none is set).
	function automatic logic [SCAN_IW-1:0] first_one8(input logic [SCAN_W-1:0] v);
		logic [SCAN_IW-1:0] r;
		r = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SCAN_IW'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/lpf_cell.sv -----
// One cell of the palindrome chain: a stored byte, a shifting partner byte
// and the palindrome bits of the two previous diagonals. Uses lpf_pkg.
`timescale 1ns / 1ps

module lpf_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpf_pkg::cell_ctl_t  ctl,
	input  logic [CNT_W-1:0]    count,
	input  logic [7:0]          ch,
	input  logic [7:0]          sh_in,
	input  logic                vld_in,
	input  logic                prev2_in,
	output logic [7:0]          sh_out,
	output logic                vld_out,
	output logic                prev2_out,
	output logic                cur
);
	import lpf_pkg::*;

	logic [7:0] char_q;
	logic [7:0] sh_q;
	logic       vld_q;
	logic       prev_q;
	logic       prev2_q;
	logic       wr_char;
	logic       wr_sh;

	// This cell stores byte IDX; its partner register first takes byte IDX+1.
	assign wr_char = ctl.wr && (count == CNT_W'(IDX));
	assign wr_sh   = ctl.wr && (count == CNT_W'(IDX + 1));

	// Byte storage; the partner byte moves down the chain one cell per diagonal.
	always_ff @(posedge clk) begin
		if (wr_char) begin
			char_q <= ch;
		end
		if (wr_sh) begin
			sh_q <= ch;
		end else if (ctl.run) begin
			sh_q <= sh_in;
		end
	end

	// The valid mark follows the partner byte, so it says whether IDX + d < n.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			prev_q  <= 1'b1;
			prev2_q <= 1'b1;
		end else if (ctl.clr) begin
			vld_q   <= 1'b0;
			prev_q  <= 1'b1;
			prev2_q <= 1'b1;
		end else begin
			if (wr_sh) begin
				vld_q <= 1'b1;
			end else if (ctl.run) begin
				vld_q <= vld_in;
			end
			if (ctl.run) begin
				prev_q  <= cur;
				prev2_q <= prev_q;
			end
		end
	end

	// Span is a palindrome when its ends match and its inner span is one.
	assign cur       = vld_q && (char_q == sh_q) && prev2_in;
	assign sh_out    = sh_q;
	assign vld_out   = vld_q;
	assign prev2_out = prev2_q;

endmodule

// ----- rtl/longest_palindrome_finder.sv -----
// Top level of the longest palindrome finder: sequencer, cell chain and
// first-hit search. Uses lpf_pkg, lpf_cell and longest_palindrome_finder_defines.svh.
`timescale 1ns / 1ps
`include "longest_palindrome_finder_defines.svh"

// Usage:
// A string is loaded one byte per item: an item is taken at a clock edge with
// start high and busy low. The item whose last flag is set ends the string.
// Bytes beyond MAX_LEN are dropped and too_long is set in the result.
// After the final byte, the cell chain steps one diagonal per cycle, up to
// diagonal n - 1 for n stored bytes, then the search for the earliest start
// on the longest diagonal scans eight positions per cycle. The result appears
// on result with done high for exactly one cycle.
// busy is high from the final byte until the result, and low again in the
// cycle that shows it, so the next string can start at once.
// The receiver cannot stall: the result is shown for one cycle only.
// Reset clears the byte count, the overflow flag and the cell state;
// the stored bytes themselves are not cleared.
module longest_palindrome_finder #(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lpf_pkg::item_t    item,
	output logic              busy,
	output logic              done,
	output lpf_pkg::result_t  result
);
	import lpf_pkg::*;

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int NCH    = (MAX_LEN + SCAN_W - 1) / SCAN_W;
	localparam int PAD_W  = NCH * SCAN_W;
	localparam int BASE_W = $clog2(PAD_W);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    d_q;
	logic [CNT_W-1:0]    snap_d_q;
	logic [CNT_W-1:0]    len_w;
	logic [PAD_W-1:0]    snap_q;
	logic [BASE_W-1:0]   base_q;
	logic [BASE_W-1:0]   hit_idx;
	logic                found_q;
	logic                overflow_q;
	logic                done_q;
	result_t             result_q;
	cell_ctl_t           ctl;
	logic                accept;
	logic                emit;
	logic                chunk_hit;
	logic [MAX_LEN-1:0]  cur_w;
	logic [7:0]          sh_w    [MAX_LEN+1];
	logic                vld_w   [MAX_LEN+1];
	logic                prev2_w [MAX_LEN+1];

	// Handshake and cell control.
	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;
	assign chunk_hit = |snap_q[SCAN_W-1:0];
	assign emit      = (state_q == ST_SCAN) && (!found_q || chunk_hit);
	assign ctl.wr    = accept && (count_q < CNT_W'(MAX_LEN));
	assign ctl.run   = (state_q == ST_RUN);
	assign ctl.clr   = emit;

	// Result fields from the last diagonal that held a palindrome.
	assign hit_idx = base_q + BASE_W'(first_one8(snap_q[SCAN_W-1:0]));
	assign len_w   = snap_d_q + CNT_W'(1);

	// Far end of the chain feeds empty bytes and true inner bits.
	assign sh_w[MAX_LEN]    = '0;
	assign vld_w[MAX_LEN]   = 1'b0;
	assign prev2_w[MAX_LEN] = 1'b1;

	// The cell chain, one cell per string position.
	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		lpf_cell #(
			.IDX   (j),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.ch        (item.ch),
			.sh_in     (sh_w[j+1]),
			.vld_in    (vld_w[j+1]),
			.prev2_in  (prev2_w[j+1]),
			.sh_out    (sh_w[j]),
			.vld_out   (vld_w[j]),
			.prev2_out (prev2_w[j]),
			.cur       (cur_w[j])
		);
	end

	// Sequencer: load, diagonal steps, first-hit search, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			d_q        <= '0;
			snap_d_q   <= '0;
			snap_q     <= '0;
			base_q     <= '0;
			found_q    <= 1'b0;
			overflow_q <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (ctl.wr) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (item.last) begin
							d_q <= CNT_W'(1);
							// A single byte has no diagonals to step.
							state_q <= (count_q == '0) ? ST_SCAN : ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (|cur_w) begin
						snap_q   <= PAD_W'(cur_w);
						snap_d_q <= d_q;
						found_q  <= 1'b1;
					end
					d_q <= d_q + CNT_W'(1);
					if (d_q + CNT_W'(1) == count_q) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (emit) begin
						done_q <= 1'b1;
						if (found_q) begin
							result_q.start_res <= 6'(hit_idx);
							result_q.length    <= 7'(len_w);
						end else begin
							result_q.start_res <= '0;
							result_q.length    <= 7'd1;
						end
						result_q.too_long <= overflow_q;
						count_q    <= '0;
						base_q     <= '0;
						found_q    <= 1'b0;
						overflow_q <= 1'b0;
						state_q    <= ST_LOAD;
					end else begin
						snap_q <= snap_q >> SCAN_W;
						base_q <= base_q + BASE_W'(SCAN_W);
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks on the sequencer.
	`LPF_ASSERT_NEXT(a_last_sets_busy, accept && item.last, busy, "final byte did not start the run")
	`LPF_ASSERT_SAME(a_ready_with_result, done, !busy, "block still busy while showing a result")
	`LPF_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held for two cycles")
	`LPF_ASSERT_SAME(a_diag_in_range, state_q == ST_RUN, d_q < count_q, "diagonal beyond string")

endmodule

// ----- tb/longest_palindrome_finder_tb.sv -----
// Self-checking testbench for the longest palindrome finder: drives strings one byte per item
// and compares each result with a built-in interval-DP predictor.
// Depends on lpf_pkg and the longest_palindrome_finder top level.
`timescale 1ns / 1ps

module longest_palindrome_finder_tb;
	import lpf_pkg::*;

	localparam int STR_CAP     = 64;
	localparam int ITEM_TARGET = 650;
	localparam int TAIL_CYCLES = 120;

	typedef logic [7:0] text_t[$];

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	// Predictor copy of the string being loaded.
	logic [7:0] str_bytes[STR_CAP];
	int         str_len;
	bit         str_dropped;

	result_t expected_spans[$];
	int      fail_count;
	int      items_sent;

	longest_palindrome_finder #(
		.MAX_LEN(STR_CAP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Interval DP over the stored bytes: span [j, j+d] is a palindrome when its
	// end bytes match and the span inside it is one. Earliest start wins ties.
	function automatic result_t longest_span();
		logic [STR_CAP-1:0] diag_d1;
		logic [STR_CAP-1:0] diag_d2;
		logic [STR_CAP-1:0] diag_cur;
		int                 best_st;
		int                 best_ln;
		result_t            r;
		diag_d1 = '1;
		diag_d2 = '1;
		best_st = 0;
		best_ln = 1;
		for (int d = 1; d < str_len; d++) begin
			diag_cur = diag_d1;
			for (int j = 0; j + d < str_len; j++) begin
				diag_cur[j] = (str_bytes[j] == str_bytes[j + d]) && (d == 1 || diag_d2[j + 1]);
				if (diag_cur[j] && d + 1 > best_ln) begin
					best_ln = d + 1;
					best_st = j;
				end
			end
			diag_d2 = diag_d1;
			diag_d1 = diag_cur;
		end
		r.start_res = best_st[5:0];
		r.length    = best_ln[6:0];
		r.too_long  = str_dropped;
		return r;
	endfunction

	// Update the predictor with one accepted item.
	task automatic absorb_byte(input item_t it);
		if (str_len < STR_CAP) begin
			str_bytes[str_len] = it.ch;
			str_len++;
		end else begin
			str_dropped = 1'b1;
		end
		if (it.last) begin
			expected_spans.push_back(longest_span());
			str_len     = 0;
			str_dropped = 1'b0;
		end
	endtask

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 24);
	endfunction

	// Offer one byte and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] c, input logic fin, input bit no_gap);
		item_t it;
		int    gap;
		it.ch   = c;
		it.last = fin;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		absorb_byte(it);
		items_sent++;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input text_t s, input bit no_gap);
		foreach (s[i]) begin
			send_byte(s[i], i == s.size() - 1, no_gap);
		end
	endtask

	// Random text over a small alphabet of random bytes, so palindromes are common.
	function automatic text_t make_text(input int len, input int alpha_n);
		logic [7:0] alpha[4];
		text_t      s;
		foreach (alpha[k]) begin
			alpha[k] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < len; i++) begin
			s.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
		end
		return s;
	endfunction

	// Random text with a mirrored tail, so a long palindrome sits at a random place.
	function automatic text_t make_mirrored(input int len);
		text_t s;
		text_t head;
		int    odd;
		head = make_text(len, 4);
		for (int i = 0; i < $urandom_range(0, 5); i++) begin
			s.push_back(8'($urandom_range(0, 255)));
		end
		odd = $urandom_range(0, 1);
		foreach (head[i]) begin
			s.push_back(head[i]);
		end
		for (int i = head.size() - 1 - odd; i >= 0; i--) begin
			s.push_back(head[i]);
		end
		for (int i = 0; i < $urandom_range(0, 5); i++) begin
			s.push_back(8'($urandom_range(0, 255)));
		end
		return s;
	endfunction

	task automatic wait_drained();
		while (expected_spans.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Short hand-picked strings: byte extremes, odd and even palindromes, ties.
	task automatic test_short_strings();
		send_text('{8'h00}, 1'b0);
		send_text('{8'hFF}, 1'b1);
		send_text('{8'h00, 8'hFF}, 1'b0);
		send_text('{8'hFF, 8'hFF}, 1'b1);
		send_text('{8'h61, 8'h62, 8'h61}, 1'b0);
		send_text('{8'h63, 8'h61, 8'h62, 8'h62, 8'h61}, 1'b0);
		send_text('{8'h61, 8'h62, 8'h61, 8'h63, 8'h64, 8'h63}, 1'b1);
		send_text('{8'h80, 8'h01, 8'h80, 8'h01, 8'h80}, 1'b0);
	endtask

	// Strings at and past capacity, including a dropped final byte.
	task automatic test_capacity();
		text_t s;
		s = {};
		for (int i = 0; i < STR_CAP; i++) begin
			s.push_back(8'h5A);
		end
		send_text(s, 1'b1);
		send_text(make_text(STR_CAP + 1, 2), 1'b0);
		send_text(make_text(STR_CAP + 6, 1), 1'b0);
		send_text(make_text(STR_CAP - 1, 2), 1'b1);
	endtask

	// The sender holds off until every result is in, then resumes at once.
	task automatic test_drain_pause();
		send_text(make_text(5, 2), 1'b1);
		send_text(make_text(9, 3), 1'b0);
		start <= 1'b0;
		wait_drained();
		send_text(make_text(1, 2), 1'b1);
		send_text(make_mirrored(4), 1'b0);
	endtask

	// Random strings, mostly short and palindrome-rich, a few near or past full size.
	task automatic test_random_strings();
		int    kind;
		bit    no_gap;
		text_t s;
		while (items_sent < ITEM_TARGET) begin
			kind   = $urandom_range(0, 9);
			no_gap = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 29) == 0) begin
				s = make_text($urandom_range(50, STR_CAP + 8), $urandom_range(1, 2));
			end else if (kind < 6) begin
				s = make_text($urandom_range(1, 12), $urandom_range(2, 3));
			end else if (kind < 8) begin
				s = make_mirrored($urandom_range(1, 10));
			end else begin
				s = make_text($urandom_range(1, 20), 4);
				foreach (s[i]) begin
					s[i] = 8'($urandom_range(0, 255));
				end
			end
			send_text(s, no_gap);
		end
	endtask

	// Compare each result with the oldest expectation, field by field.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (expected_spans.size() == 0) begin
				$display("%0t: unexpected result start_res=%0d length=%0d too_long=%0b",
					$time, result.start_res, result.length, result.too_long);
				fail_count++;
			end else begin
				exp_r = expected_spans.pop_front();
				if (result.start_res !== exp_r.start_res) begin
					$display("%0t: start_res mismatch: expected %0d, actual %0d",
						$time, exp_r.start_res, result.start_res);
					fail_count++;
				end
				if (result.length !== exp_r.length) begin
					$display("%0t: length mismatch: expected %0d, actual %0d",
						$time, exp_r.length, result.length);
					fail_count++;
				end
				if (result.too_long !== exp_r.too_long) begin
					$display("%0t: too_long mismatch: expected %0b, actual %0b",
						$time, exp_r.too_long, result.too_long);
					fail_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		str_len     = 0;
		str_dropped = 1'b0;
		fail_count  = 0;
		items_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_strings();
		test_capacity();
		test_drain_pause();
		test_random_strings();

		start <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
